/* rtl/core/sfla_pkg.sv */
package sfla_pkg;

    localparam int SLOT_W   = 10;
    localparam int SERIAL_W = 32;
    localparam int CNT_W    = 11;
    localparam int BATCH_W  = 7;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    // slot and batch_count in tdata, padded to whole bytes
    localparam int S_TDATA_W = 24;
    // slot_out, serial_id and active in tdata, padded to whole bytes
    localparam int M_TDATA_W = 56;

    // largest value the slot count register can hold
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SPAWN   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_BATCH   = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_NONE    = 2'd1,
        STAT_BAD_IDX = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

endpackage

/* rtl/core/sfla_ram.sv */
module sfla_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/slot_free_list_allocator.sv */
// Slot allocator over a LIFO free list of slot indices held in one RAM.
// Input channel s_*: s_tuser carries the function (spawn, release, batch
// spawn, clear), s_tdata the slot to release and the batch size.
// Result channel m_*: one transfer per input, or one per slot popped on a
// batch spawn, with tlast on the final one; m_tuser carries the status.
// cfg_wr_en/cfg_wr_data set the number of managed slots (clamped to
// 1..MAX_SLOTS); it takes effect on the index checks at once and on the
// list at the next clear.
// Release, clear and failed requests answer from the output register, loaded
// at acceptance. A spawn reads the stack RAM at acceptance and loads the RAM
// output into the output register; a batch spawn then gives one slot per
// cycle while the output register is free, since each pop issues the next
// RAM read while the previous result is loaded. A new item is taken only once
// all results of the previous one sit in the output register.
// After reset the list holds all slots in index order with no RAM sweep: a
// low-water mark tracks which stack entries were rewritten since the last
// reload, and entries below it read as their own index. The block is ready
// in the first cycle after reset. When m_tready is low the result register
// holds and no further item or pop proceeds.
module slot_free_list_allocator
    import sfla_pkg::*;
#(
    parameter int MAX_SLOTS = 1024,
    parameter int MAX_BATCH = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CNT_W-1:0]     cfg_wr_data,   // slots_in_use

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // [9:0] slot, [16:10] batch_count, rest 0
    input  logic [FUNC_W-1:0]    s_tuser,       // [1:0] func

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,       // [9:0] slot_out, [41:10] serial_id,
                                                // [52:42] active, rest 0
    output logic [STATUS_W-1:0]  m_tuser,       // [1:0] status
    output logic                 m_tlast
);

    localparam int AW        = $clog2(MAX_SLOTS);
    localparam int RW        = $clog2(MAX_BATCH + 1);
    localparam int MAX_CNT   = (MAX_SLOTS > CNT_MAX) ? CNT_MAX : MAX_SLOTS;
    localparam int RESET_SIU = (MAX_SLOTS > 1024) ? 1024 : MAX_SLOTS;

    typedef enum logic {
        ST_IDLE,
        ST_FILL
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      siu_reg, siu_next;
    logic [CNT_W-1:0]      top_reg, top_next;
    logic [CNT_W-1:0]      low_reg, low_next;
    logic [CNT_W-1:0]      active_reg, active_next;
    logic [SERIAL_W-1:0]   id_reg, id_next;
    logic [RW-1:0]         rem_reg, rem_next;

    logic                  pend_direct_reg, pend_direct_next;
    logic [AW-1:0]         pend_idx_reg, pend_idx_next;
    logic [SERIAL_W-1:0]   pend_serial_reg, pend_serial_next;
    logic [CNT_W-1:0]      pend_active_reg, pend_active_next;

    logic                  m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0]     m_slot_reg, m_slot_next;
    logic [SERIAL_W-1:0]   m_serial_reg, m_serial_next;
    status_t               m_status_reg, m_status_next;
    logic [CNT_W-1:0]      m_active_reg, m_active_next;
    logic                  m_last_reg, m_last_next;

    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [AW-1:0]         ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [AW-1:0]         ram_rd_data;

    logic                  out_free;
    logic                  in_xfer;
    func_t                 in_func;
    logic [SLOT_W-1:0]     in_slot;
    logic [BATCH_W-1:0]    in_batch;
    logic [CNT_W-1:0]      pop_pos;
    logic [CNT_W-1:0]      batch_n;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_xfer  = s_tvalid && s_tready;
    assign in_func  = func_t'(s_tuser);
    assign in_slot  = s_tdata[SLOT_W-1:0];
    assign in_batch = s_tdata[SLOT_W +: BATCH_W];
    assign pop_pos  = top_reg - CNT_W'(1);

    // batch size clamped to the free count and to MAX_BATCH
    always_comb begin
        batch_n = CNT_W'(in_batch);
        if (batch_n > top_reg) begin
            batch_n = top_reg;
        end
        if (batch_n > CNT_W'(MAX_BATCH)) begin
            batch_n = CNT_W'(MAX_BATCH);
        end
    end

    always_comb begin
        state_next       = state_reg;
        siu_next         = siu_reg;
        top_next         = top_reg;
        low_next         = low_reg;
        active_next      = active_reg;
        id_next          = id_reg;
        rem_next         = rem_reg;
        pend_direct_next = pend_direct_reg;
        pend_idx_next    = pend_idx_reg;
        pend_serial_next = pend_serial_reg;
        pend_active_next = pend_active_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_slot_next      = m_slot_reg;
        m_serial_next    = m_serial_reg;
        m_status_next    = m_status_reg;
        m_active_next    = m_active_reg;
        m_last_next      = m_last_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = AW'(top_reg);
        ram_wr_data      = AW'(in_slot);
        ram_rd_en        = 1'b0;
        ram_rd_addr      = AW'(pop_pos);

        if (cfg_wr_en) begin
            if (cfg_wr_data == '0) begin
                siu_next = CNT_W'(1);
            end else if (cfg_wr_data > CNT_W'(MAX_CNT)) begin
                siu_next = CNT_W'(MAX_CNT);
            end else begin
                siu_next = cfg_wr_data;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    m_slot_next   = '0;
                    m_serial_next = '0;
                    m_active_next = active_reg;
                    m_last_next   = 1'b1;
                    unique case (in_func)
                        FUNC_SPAWN: begin
                            if (top_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = STAT_NONE;
                            end else begin
                                ram_rd_en  = 1'b1;
                                rem_next   = RW'(1);
                                state_next = ST_FILL;
                            end
                        end
                        FUNC_RELEASE: begin
                            m_valid_next = 1'b1;
                            m_slot_next  = in_slot;
                            if (CNT_W'(in_slot) >= siu_reg) begin
                                m_status_next = STAT_BAD_IDX;
                            end else if (top_reg >= siu_reg) begin
                                m_status_next = STAT_FULL;
                            end else begin
                                ram_wr_en     = 1'b1;
                                top_next      = top_reg + CNT_W'(1);
                                m_status_next = STAT_OK;
                                if (active_reg != '0) begin
                                    active_next   = active_reg - CNT_W'(1);
                                    m_active_next = active_reg - CNT_W'(1);
                                end
                            end
                        end
                        FUNC_BATCH: begin
                            if (batch_n == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = STAT_NONE;
                            end else begin
                                ram_rd_en  = 1'b1;
                                rem_next   = RW'(batch_n);
                                state_next = ST_FILL;
                            end
                        end
                        FUNC_CLEAR: begin
                            top_next      = siu_reg;
                            low_next      = siu_reg;
                            active_next   = '0;
                            m_valid_next  = 1'b1;
                            m_status_next = STAT_OK;
                            m_active_next = '0;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_slot_next   = pend_direct_reg ? SLOT_W'(pend_idx_reg)
                                                    : SLOT_W'(ram_rd_data);
                    m_serial_next = pend_serial_reg;
                    m_status_next = STAT_OK;
                    m_active_next = pend_active_reg;
                    m_last_next   = (rem_reg == RW'(1));
                    if (rem_reg == RW'(1)) begin
                        rem_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        ram_rd_en = 1'b1;
                        rem_next  = rem_reg - RW'(1);
                    end
                end
            end
        endcase

        // one pop: entries below the low-water mark still hold their own index
        if (ram_rd_en) begin
            top_next         = pop_pos;
            active_next      = active_reg + CNT_W'(1);
            id_next          = id_reg + SERIAL_W'(1);
            pend_idx_next    = AW'(pop_pos);
            pend_direct_next = (pop_pos < low_reg);
            pend_serial_next = id_reg;
            pend_active_next = active_reg + CNT_W'(1);
            if (pop_pos < low_reg) begin
                low_next = pop_pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            siu_reg     <= CNT_W'(RESET_SIU);
            top_reg     <= CNT_W'(RESET_SIU);
            low_reg     <= CNT_W'(RESET_SIU);
            active_reg  <= '0;
            id_reg      <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            siu_reg     <= siu_next;
            top_reg     <= top_next;
            low_reg     <= low_next;
            active_reg  <= active_next;
            id_reg      <= id_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
        pend_direct_reg <= pend_direct_next;
        pend_idx_reg    <= pend_idx_next;
        pend_serial_reg <= pend_serial_next;
        pend_active_reg <= pend_active_next;
        m_slot_reg      <= m_slot_next;
        m_serial_reg    <= m_serial_next;
        m_status_reg    <= m_status_next;
        m_active_reg    <= m_active_next;
        m_last_reg      <= m_last_next;
    end

    sfla_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_SLOTS)
    ) u_stack (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - SLOT_W - SERIAL_W - CNT_W){1'b0}},
                       m_active_reg, m_serial_reg, m_slot_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    // free plus active never exceeds MAX_CNT
    assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, top_reg} + {1'b0, active_reg}) <= (CNT_W + 1)'(MAX_CNT))
        else $error("free plus active slots exceed the slot bound");

    // the low-water mark never sits above the stack top
    assert property (@(posedge aclk) disable iff (!aresetn)
        low_reg <= top_reg)
        else $error("low-water mark above stack top");

    // a pending pop always has a result left to deliver
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |-> (rem_reg != '0))
        else $error("pop pending with nothing left to deliver");

    // a pop never runs on an empty list
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_rd_en |-> (top_reg != '0))
        else $error("pop issued on an empty free list");

    // only a successful spawn carries a serial id
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != STAT_OK)) |-> (m_serial_reg == '0))
        else $error("failed result carries a serial id");

endmodule
